// ===== rtl/core/gbnp_pkg.sv =====
// Shared types, constants and helpers for the grid bucket nearest point block.
// No dependencies; every other file in rtl/core but gbnp_fifo imports this package.
`default_nettype none
package gbnp_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int PIDX_W     = 10;
	localparam int CNT_W      = PIDX_W + 1;
	localparam int GRID_DIM   = 16;
	localparam int CELL_COUNT = GRID_DIM * GRID_DIM * GRID_DIM;
	localparam int CELL_W     = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CLIP_HI    = GRID_DIM + 1;

	// input operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// result status codes
	localparam logic [2:0] ST_STORED  = 3'd0;
	localparam logic [2:0] ST_FOUND   = 3'd1;
	localparam logic [2:0] ST_NONE    = 3'd2;
	localparam logic [2:0] ST_OUTSIDE = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_CELLS = 3'd6;

	localparam logic [30:0] SIZE_RESET = 31'd65536;
	localparam logic [11:0] GRID_RESET = 12'd4095;

	typedef logic signed [5:0] ccoord_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic [30:0]        size_x;
		logic [30:0]        size_y;
		logic [30:0]        size_z;
		logic [11:0]        grid_cells;
	} cfg_t;

	typedef struct packed {
		logic               op;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		ccoord_t            ci;
		ccoord_t            cj;
		ccoord_t            ck;
		logic               in_grid;
	} item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [PIDX_W-1:0] index;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0]  fill;
		logic [PIDX_W-1:0] last;
		logic [PIDX_W-1:0] first;
	} cell_t;

	// cells along one axis from its 4-bit field
	function automatic logic [4:0] axis_dim(input logic [3:0] f);
		return {1'b0, f} + 5'd1;
	endfunction

	// true when a signed cell coordinate lies in 0..n-1
	function automatic logic in_axis(input logic [6:0] c, input logic [4:0] n);
		return !c[6] && (c[5:0] < {1'b0, n});
	endfunction

	// linear cell number x + nx*y + nx*ny*z
	function automatic logic [CELL_W-1:0] cell_index(input logic [3:0] a, input logic [3:0] b,
			input logic [3:0] c, input logic [4:0] nx, input logic [4:0] ny);
		logic [13:0] s;
		s = 14'(a) + 14'(nx) * 14'(b) + 14'(nx) * 14'(ny) * 14'(c);
		return s[CELL_W-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/gbnp_fifo.sv =====
// Two-entry queue of generic words, registered storage.
// No package dependency.
`default_nettype none
module gbnp_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             rd,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             wr_ok, rd_ok;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign wr_ok = wr && !full;
	assign rd_ok = rd && !empty;
	assign rdata = mem_q[rp_q];

	// store words
	always_ff @(posedge clk) begin
		if (wr_ok) mem_q[wp_q] <= wdata;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_ok) wp_q <= ~wp_q;
			if (rd_ok) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_ok) - 2'(rd_ok);
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gbnp_div.sv =====
// Restoring divider for one axis: floor((coord - origin) / size), one bit a cycle,
// clipped to the range that matters for the grid. Depends on gbnp_pkg.
`default_nettype none
module gbnp_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] coord,
	input  wire logic signed [31:0] origin,
	input  wire logic [30:0]        size,
	output logic                    busy,
	output gbnp_pkg::ccoord_t       bucket
);
	import gbnp_pkg::*;

	logic [32:0]        quo_q;
	logic [30:0]        rem_q, div_q;
	logic               neg_q, busy_q;
	logic [5:0]         step_q;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [31:0]        trial;
	logic               take;

	assign diff  = 33'(coord) - 33'(origin);
	assign mag   = diff[32] ? 33'(-diff) : diff;
	assign trial = {rem_q, quo_q[32]};
	assign take  = trial >= {1'b0, div_q};
	assign busy  = busy_q;

	// shift one dividend bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			div_q <= (size == 31'd0) ? 31'd1 : size;
			neg_q <= diff[32];
		end else if (busy_q) begin
			rem_q <= take ? 31'(trial - {1'b0, div_q}) : trial[30:0];
			quo_q <= {quo_q[31:0], take};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 6'd1;
			if (step_q == 6'd32) busy_q <= 1'b0;
		end
	end

	// floor and clip: anything two cells outside acts the same
	always_comb begin
		if (!neg_q) begin
			bucket = (quo_q >= 33'(CLIP_HI)) ? ccoord_t'(CLIP_HI) : ccoord_t'(quo_q[5:0]);
		end else if (quo_q >= 33'd2 || (quo_q == 33'd1 && rem_q != '0)) begin
			bucket = -6'sd2;
		end else if (quo_q == 33'd1 || rem_q != '0) begin
			bucket = -6'sd1;
		end else begin
			bucket = 6'sd0;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gbnp_front.sv =====
// Front end: accepts words, finds the cell of each point and queues it for the back end.
// Depends on gbnp_pkg and gbnp_div.
`default_nettype none
module gbnp_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  gbnp_pkg::cfg_t          cfg,
	input  wire logic               push,
	output logic                    full,
	input  wire logic               op,
	input  wire logic signed [31:0] coord_x,
	input  wire logic signed [31:0] coord_y,
	input  wire logic signed [31:0] coord_z,
	input  wire logic               clearing,
	output logic                    mid_push,
	output gbnp_pkg::item_t         mid_item,
	input  wire logic               mid_full
);
	import gbnp_pkg::*;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_DIV  = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]         state_q;
	logic               op_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic               accept;
	logic               busy_x, busy_y, busy_z;
	ccoord_t            cell_x, cell_y, cell_z;

	assign full   = (state_q != F_IDLE) || clearing;
	assign accept = push && !full;

	gbnp_div u_div_x (.clk, .arst_n, .start(accept), .coord(coord_x), .origin(cfg.origin_x),
		.size(cfg.size_x), .busy(busy_x), .bucket(cell_x));
	gbnp_div u_div_y (.clk, .arst_n, .start(accept), .coord(coord_y), .origin(cfg.origin_y),
		.size(cfg.size_y), .busy(busy_y), .bucket(cell_y));
	gbnp_div u_div_z (.clk, .arst_n, .start(accept), .coord(coord_z), .origin(cfg.origin_z),
		.size(cfg.size_z), .busy(busy_z), .bucket(cell_z));

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			x_q  <= coord_x;
			y_q  <= coord_y;
			z_q  <= coord_z;
		end
	end

	// classify and hand over
	always_comb begin
		mid_item.op      = op_q;
		mid_item.x       = x_q;
		mid_item.y       = y_q;
		mid_item.z       = z_q;
		mid_item.ci      = cell_x;
		mid_item.cj      = cell_y;
		mid_item.ck      = cell_z;
		mid_item.in_grid = in_axis({cell_x[5], cell_x}, axis_dim(cfg.grid_cells[3:0]))
			&& in_axis({cell_y[5], cell_y}, axis_dim(cfg.grid_cells[7:4]))
			&& in_axis({cell_z[5], cell_z}, axis_dim(cfg.grid_cells[11:8]));
	end
	assign mid_push = (state_q == F_PUSH) && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (accept) state_q <= F_DIV;
				F_DIV:  if (!busy_x && !busy_y && !busy_z) state_q <= F_PUSH;
				F_PUSH: if (!mid_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/gbnp_back.sv =====
// Back end: owns the point and cell memories, stores loads and walks the 27 cells of a query.
// Depends on gbnp_pkg.
`default_nettype none
module gbnp_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  gbnp_pkg::cfg_t   cfg,
	input  wire logic        mid_empty,
	input  gbnp_pkg::item_t  mid_item,
	output logic             mid_pop,
	input  wire logic        out_full,
	output logic             out_push,
	output gbnp_pkg::result_t out_res,
	output logic             clearing
);
	import gbnp_pkg::*;

	localparam logic [3:0] B_CLR  = 4'd0;
	localparam logic [3:0] B_IDLE = 4'd1;
	localparam logic [3:0] B_LDWR = 4'd2;
	localparam logic [3:0] Q_OFF  = 4'd3;
	localparam logic [3:0] Q_CELL = 4'd4;
	localparam logic [3:0] Q_DIFF = 4'd5;
	localparam logic [3:0] Q_MUL  = 4'd6;
	localparam logic [3:0] Q_SUM  = 4'd7;
	localparam logic [3:0] Q_CMP  = 4'd8;
	localparam logic [3:0] B_RES  = 4'd9;

	// memories
	cell_t             cell_mem [CELL_COUNT];
	cell_t             cell_rd;
	logic [95:0]       pt_mem [MAX_POINTS];
	logic [95:0]       pt_rd;
	logic [PIDX_W-1:0] next_mem [MAX_POINTS];
	logic [PIDX_W-1:0] next_rd;

	logic              cell_re, cell_we, pt_re, pt_we, next_we;
	logic [CELL_W-1:0] cell_ra, cell_wa;
	cell_t             cell_wd;
	logic [PIDX_W-1:0] pt_ra, new_idx;

	logic [3:0]        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CELL_W-1:0] clr_q, ld_wa_q;
	logic [1:0]        di_q, dj_q, dk_q;
	logic [PIDX_W-1:0] pidx_q, nxt_q, best_idx_q;
	logic [CNT_W-1:0]  left_q;
	logic [31:0]       dx_q, dy_q, dz_q;
	logic [63:0]       sqx_q, sqy_q, sqz_q;
	logic [65:0]       sum_q, best_q;
	logic              found_q;
	result_t           res_q;

	logic [4:0]        nx, ny, nz;
	logic [6:0]        ax, ay, az;
	logic              inb, last_off, adv;
	logic [CELL_W-1:0] off_cell, ld_cell;

	function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32] ? 32'(-d) : d[31:0];
	endfunction

	assign nx = axis_dim(cfg.grid_cells[3:0]);
	assign ny = axis_dim(cfg.grid_cells[7:4]);
	assign nz = axis_dim(cfg.grid_cells[11:8]);

	// neighbor cell at the current offset
	assign ax = {mid_item.ci[5], mid_item.ci} + {5'd0, di_q} - 7'd1;
	assign ay = {mid_item.cj[5], mid_item.cj} + {5'd0, dj_q} - 7'd1;
	assign az = {mid_item.ck[5], mid_item.ck} + {5'd0, dk_q} - 7'd1;
	assign inb = in_axis(ax, nx) && in_axis(ay, ny) && in_axis(az, nz);
	assign off_cell = cell_index(ax[3:0], ay[3:0], az[3:0], nx, ny);
	assign ld_cell = cell_index(mid_item.ci[3:0], mid_item.cj[3:0], mid_item.ck[3:0], nx, ny);
	assign last_off = (di_q == 2'd2) && (dj_q == 2'd2) && (dk_q == 2'd2);
	assign new_idx = count_q[PIDX_W-1:0];
	assign clearing = state_q == B_CLR;

	// sequence control and memory ports
	always_comb begin
		state_d  = state_q;
		cell_re  = 1'b0;
		cell_ra  = off_cell;
		cell_we  = 1'b0;
		cell_wa  = ld_wa_q;
		cell_wd  = '0;
		pt_re    = 1'b0;
		pt_ra    = nxt_q;
		pt_we    = 1'b0;
		next_we  = 1'b0;
		mid_pop  = 1'b0;
		out_push = 1'b0;
		adv      = 1'b0;
		unique case (state_q)
			B_CLR: begin
				cell_we = 1'b1;
				cell_wa = clr_q;
				if (clr_q == CELL_W'(CELL_COUNT - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!mid_empty) begin
					if (mid_item.op == OP_LOAD) begin
						if (!mid_item.in_grid || count_q[PIDX_W]) begin
							state_d = B_RES;
						end else begin
							cell_re = 1'b1;
							cell_ra = ld_cell;
							state_d = B_LDWR;
						end
					end else begin
						state_d = Q_OFF;
					end
				end
			end
			B_LDWR: begin
				cell_we       = 1'b1;
				cell_wd.fill  = cell_rd.fill + CNT_W'(1);
				cell_wd.last  = new_idx;
				cell_wd.first = (cell_rd.fill == '0) ? new_idx : cell_rd.first;
				pt_we         = 1'b1;
				next_we       = cell_rd.fill != '0;
				state_d       = B_RES;
			end
			Q_OFF: begin
				if (inb) begin
					cell_re = 1'b1;
					state_d = Q_CELL;
				end else begin
					adv     = 1'b1;
					state_d = last_off ? B_RES : Q_OFF;
				end
			end
			Q_CELL: begin
				if (cell_rd.fill == '0) begin
					adv     = 1'b1;
					state_d = last_off ? B_RES : Q_OFF;
				end else begin
					pt_re   = 1'b1;
					pt_ra   = cell_rd.first;
					state_d = Q_DIFF;
				end
			end
			Q_DIFF: state_d = Q_MUL;
			Q_MUL:  state_d = Q_SUM;
			Q_SUM:  state_d = Q_CMP;
			Q_CMP: begin
				if (left_q == CNT_W'(1)) begin
					adv     = 1'b1;
					state_d = last_off ? B_RES : Q_OFF;
				end else begin
					pt_re   = 1'b1;
					state_d = Q_DIFF;
				end
			end
			B_RES: begin
				if (!out_full) begin
					out_push = 1'b1;
					mid_pop  = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// cell table: first, last and fill of each list
	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		if (cell_re) cell_rd <= cell_mem[cell_ra];
	end

	// point store and list links
	always_ff @(posedge clk) begin
		if (pt_we) pt_mem[new_idx] <= {mid_item.x, mid_item.y, mid_item.z};
		if (pt_re) pt_rd <= pt_mem[pt_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[cell_rd.last] <= new_idx;
		if (pt_re) next_rd <= next_mem[pt_ra];
	end

	// distance datapath and best candidate
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) ld_wa_q <= ld_cell;
		if (pt_re) pidx_q <= pt_ra;
		if (state_q == Q_CELL) left_q <= cell_rd.fill;
		if (state_q == Q_DIFF) begin
			dx_q  <= abs_diff(mid_item.x, pt_rd[95:64]);
			dy_q  <= abs_diff(mid_item.y, pt_rd[63:32]);
			dz_q  <= abs_diff(mid_item.z, pt_rd[31:0]);
			nxt_q <= next_rd;
		end
		if (state_q == Q_MUL) begin
			sqx_q <= dx_q * dx_q;
			sqy_q <= dy_q * dy_q;
			sqz_q <= dz_q * dz_q;
		end
		if (state_q == Q_SUM) sum_q <= 66'(sqx_q) + 66'(sqy_q) + 66'(sqz_q);
		if (state_q == Q_CMP) begin
			left_q <= left_q - CNT_W'(1);
			if (!found_q || sum_q <= best_q) begin
				best_q     <= sum_q;
				best_idx_q <= pidx_q;
			end
		end
		// load results
		if (state_q == B_IDLE) begin
			res_q.status <= mid_item.in_grid ? ST_FULL : ST_OUTSIDE;
			res_q.index  <= '0;
		end
		if (state_q == B_LDWR) begin
			res_q.status <= ST_STORED;
			res_q.index  <= new_idx;
		end
	end

	always_comb begin
		if (mid_item.op == OP_QUERY) begin
			out_res.status = found_q ? ST_FOUND : ST_NONE;
			out_res.index  = found_q ? best_idx_q : '0;
		end else begin
			out_res = res_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q   <= '0;
			count_q <= '0;
			found_q <= 1'b0;
			di_q    <= '0;
			dj_q    <= '0;
			dk_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLR) clr_q <= clr_q + CELL_W'(1);
			if (state_q == B_LDWR) count_q <= count_q + CNT_W'(1);
			if (state_q == B_IDLE) begin
				found_q <= 1'b0;
				di_q    <= '0;
				dj_q    <= '0;
				dk_q    <= '0;
			end
			if (state_q == Q_CMP) found_q <= 1'b1;
			if (adv && !last_off) begin
				if (di_q != 2'd2) begin
					di_q <= di_q + 2'd1;
				end else begin
					di_q <= '0;
					if (dj_q != 2'd2) begin
						dj_q <= dj_q + 2'd1;
					end else begin
						dj_q <= '0;
						dk_q <= dk_q + 2'd1;
					end
				end
			end
		end
	end

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CNT_W'(1)))
		else $error("point count moved by more than one");
	a_push_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (state_q == B_RES) && mid_pop)
		else $error("result pushed outside result state");
	a_clr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !mid_pop && !out_push && !pt_we)
		else $error("work done during clearing pass");
endmodule
`default_nettype wire

// ===== rtl/core/grid_bucket_nearest_point.sv =====
// Uniform grid nearest point search. A load passes the cell divider, the queue handoff
// and one cell table read and write; a query passes the divider and handoff, walks the
// 27 cells of its neighbourhood and sends each stored point visited, one at a time, through the
// difference, square, sum and compare steps. Results wait in a two-word queue; the
// front may finish the next word meanwhile. After reset a clearing pass empties all
// 4096 cell table entries; full stays high until it ends. Configuration writes are taken at any time.
// Depends on gbnp_pkg, gbnp_front, gbnp_back, gbnp_fifo.
`default_nettype none
module grid_bucket_nearest_point (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic                           op,
	input  wire logic signed [31:0]             coord_x,
	input  wire logic signed [31:0]             coord_y,
	input  wire logic signed [31:0]             coord_z,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [2:0]                          status,
	output logic [gbnp_pkg::PIDX_W-1:0]         point_index,
	input  wire logic                           cfg_we,
	input  wire logic [gbnp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]                    cfg_data
);
	import gbnp_pkg::*;

	localparam int ITEM_W = $bits(item_t);
	localparam int RES_W  = $bits(result_t);

	cfg_t              cfg_q;
	logic              clearing, mid_push, mid_full, mid_empty, mid_pop;
	item_t             front_item, mid_item;
	logic [ITEM_W-1:0] mid_word;
	logic              out_push, out_full;
	result_t           back_res, out_res;
	logic [RES_W-1:0]  out_word;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x   <= '0;
			cfg_q.origin_y   <= '0;
			cfg_q.origin_z   <= '0;
			cfg_q.size_x     <= SIZE_RESET;
			cfg_q.size_y     <= SIZE_RESET;
			cfg_q.size_z     <= SIZE_RESET;
			cfg_q.grid_cells <= GRID_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data;
				REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data;
				REG_ORIGIN_Z:   cfg_q.origin_z   <= cfg_data;
				REG_SIZE_X:     cfg_q.size_x     <= cfg_data[30:0];
				REG_SIZE_Y:     cfg_q.size_y     <= cfg_data[30:0];
				REG_SIZE_Z:     cfg_q.size_z     <= cfg_data[30:0];
				REG_GRID_CELLS: cfg_q.grid_cells <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	gbnp_front u_front (
		.clk, .arst_n, .cfg(cfg_q), .push, .full, .op, .coord_x, .coord_y, .coord_z,
		.clearing, .mid_push, .mid_item(front_item), .mid_full
	);

	gbnp_fifo #(.WIDTH(ITEM_W)) u_mid_q (
		.clk, .arst_n, .wr(mid_push), .wdata(front_item), .full(mid_full),
		.rd(mid_pop), .rdata(mid_word), .empty(mid_empty)
	);
	assign mid_item = item_t'(mid_word);

	gbnp_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .mid_empty, .mid_item, .mid_pop,
		.out_full, .out_push, .out_res(back_res), .clearing
	);

	gbnp_fifo #(.WIDTH(RES_W)) u_out_q (
		.clk, .arst_n, .wr(out_push), .wdata(back_res), .full(out_full),
		.rd(pop), .rdata(out_word), .empty
	);
	assign out_res     = result_t'(out_word);
	assign status      = out_res.status;
	assign point_index = out_res.index;
endmodule
`default_nettype wire
